/* sv/rcpwm_pkg.sv */
package rcpwm_pkg;

  localparam int unsigned NumChannels = 8;
  localparam int unsigned ChanBits    = 3;
  localparam int unsigned TsBits      = 16;
  localparam int unsigned CfgBits     = 16;

  localparam logic [TsBits-1:0] FailsafeWidth = 16'd1000;
  localparam logic [7:0]        SilentMax     = 8'd255;

  typedef enum logic {
    OP_EDGE = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_CENTERED_MASK = 3'd0,
    REG_CENTER_VALUE  = 3'd1,
    REG_DEADBAND_HALF = 3'd2,
    REG_REJECT_LOW    = 3'd3,
    REG_REJECT_HIGH   = 3'd4,
    REG_CLAMP_LOW     = 3'd5,
    REG_CLAMP_HIGH    = 3'd6,
    REG_TIMEOUT_TICKS = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    op_t                 op;
    logic [ChanBits-1:0] channel;
    logic [TsBits-1:0]   timestamp;
  } in_item_t;

  typedef struct packed {
    logic [ChanBits-1:0] out_channel;
    logic [15:0]         raw_width;
    logic [15:0]         filtered_width;
    logic                timed_out;
    logic                last;
  } out_item_t;

  typedef struct packed {
    logic        centered;
    logic [15:0] center_value;
    logic [9:0]  deadband_half;
    logic [15:0] reject_low;
    logic [15:0] reject_high;
    logic [15:0] clamp_low;
    logic [15:0] clamp_high;
  } filt_cfg_t;

  // Deadband / reject / clamp chain, applied in that order.
  function automatic logic [15:0] pulse_filter(input filt_cfg_t c, input logic [15:0] w);
    logic        outside;
    logic        in_band;
    logic [16:0] w_plus_d;
    logic [16:0] c_plus_d;
    logic [15:0] v;
    begin
      outside  = (w < c.reject_low) || (w > c.reject_high);
      w_plus_d = {1'b0, w} + {7'd0, c.deadband_half};
      c_plus_d = {1'b0, c.center_value} + {7'd0, c.deadband_half};
      in_band  = (w_plus_d >= {1'b0, c.center_value}) && ({1'b0, w} <= c_plus_d);
      v = w;
      if (c.centered) begin
        if (in_band || outside) v = c.center_value;
      end else if (outside) begin
        v = c.clamp_low;
      end
      if ((v < c.clamp_low) && (v > c.reject_low)) v = c.clamp_low;
      if ((v > c.clamp_high) && (v < c.reject_high)) v = c.clamp_high;
      return v;
    end
  endfunction

endpackage

/* sv/rc_pwm_pulse_decoder.sv */
// Channel  Signals                          Beat taken when
// in       in_valid, in_ready, in_data      in_valid && in_ready
// out      out_valid, out_ready, out_data   out_valid && out_ready
// cfg      cfg_we, cfg_index, cfg_wdata     cfg_we
//
// An edge beat that closes a pulse has its result in the output register on the
// next cycle. A tick beat latches the set of channels that time out and then sends
// one failsafe result a cycle while the output register is free, lowest channel first;
// in_ready stays low until that set is empty.
// Reset (synchronous, rst_n low) clears all channel state and loads register defaults.
// A stalled output register holds its beat and blocks further input.
module rc_pwm_pulse_decoder
  import rcpwm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  cfg_idx_t             cfg_index,
  input  logic [CfgBits-1:0]   cfg_wdata
);

  logic [NumChannels-1:0] centered_mask_r;
  logic [15:0]            center_value_r;
  logic [9:0]             deadband_half_r;
  logic [15:0]            reject_low_r;
  logic [15:0]            reject_high_r;
  logic [15:0]            clamp_low_r;
  logic [15:0]            clamp_high_r;
  logic [7:0]             timeout_ticks_r;

  logic [NumChannels-1:0] awaiting_r, awaiting_nxt;
  logic [TsBits-1:0]      first_time_r [NumChannels];
  logic [7:0]             silent_r [NumChannels];
  logic [7:0]             silent_nxt [NumChannels];
  logic [NumChannels-1:0] reported_r, reported_nxt;
  logic [NumChannels-1:0] pend_r, pend_nxt;

  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_r, out_nxt;

  logic                   slot_free;
  logic                   in_fire;
  logic                   edge_fire;
  logic                   tick_fire;
  logic [ChanBits-1:0]    sel_ch;
  logic [NumChannels-1:0] pend_rest;
  logic [15:0]            width;
  filt_cfg_t              edge_cfg;
  filt_cfg_t              fs_cfg;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = slot_free && (pend_r == '0);
  assign in_fire   = in_valid && in_ready;
  assign edge_fire = in_fire && (in_data.op == OP_EDGE);
  assign tick_fire = in_fire && (in_data.op == OP_TICK);

  // Wrap case (new time not above stored time): 16'hFFFF minus stored time plus new time, never above 16 bits.
  assign width = (in_data.timestamp > first_time_r[in_data.channel])
               ? in_data.timestamp - first_time_r[in_data.channel]
               : 16'hFFFF - (first_time_r[in_data.channel] - in_data.timestamp);

  always_comb begin
    sel_ch = '0;
    for (int i = NumChannels - 1; i >= 0; i--) begin
      if (pend_r[i]) sel_ch = ChanBits'(i);
    end
    pend_rest = pend_r & ~(NumChannels'(1) << sel_ch);
  end

  always_comb begin
    edge_cfg = '{centered: centered_mask_r[in_data.channel], center_value: center_value_r,
                 deadband_half: deadband_half_r, reject_low: reject_low_r,
                 reject_high: reject_high_r, clamp_low: clamp_low_r,
                 clamp_high: clamp_high_r};
    fs_cfg          = edge_cfg;
    fs_cfg.centered = centered_mask_r[sel_ch];
  end

  // Channel state update.
  always_comb begin
    awaiting_nxt = awaiting_r;
    reported_nxt = reported_r;
    pend_nxt     = pend_r;
    for (int i = 0; i < NumChannels; i++) silent_nxt[i] = silent_r[i];

    if (slot_free && (pend_r != '0)) pend_nxt = pend_rest;

    if (edge_fire) begin
      silent_nxt[in_data.channel]   = '0;
      reported_nxt[in_data.channel] = 1'b0;
      awaiting_nxt[in_data.channel] = !awaiting_r[in_data.channel];
    end else if (tick_fire) begin
      for (int i = 0; i < NumChannels; i++) begin
        if (silent_r[i] != SilentMax) silent_nxt[i] = silent_r[i] + 8'd1;
        if ((silent_nxt[i] > timeout_ticks_r) && !reported_r[i]) begin
          reported_nxt[i] = 1'b1;
          pend_nxt[i]     = 1'b1;
        end
      end
    end
  end

  // Output register load: drain failsafe results first, else a finished edge pair.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    if (slot_free && (pend_r != '0)) begin
      out_valid_nxt          = 1'b1;
      out_nxt.out_channel    = sel_ch;
      out_nxt.raw_width      = FailsafeWidth;
      out_nxt.filtered_width = pulse_filter(fs_cfg, FailsafeWidth);
      out_nxt.timed_out      = 1'b1;
      out_nxt.last           = (pend_rest == '0);
    end else if (edge_fire && awaiting_r[in_data.channel]) begin
      out_valid_nxt          = 1'b1;
      out_nxt.out_channel    = in_data.channel;
      out_nxt.raw_width      = width;
      out_nxt.filtered_width = pulse_filter(edge_cfg, width);
      out_nxt.timed_out      = 1'b0;
      out_nxt.last           = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r  <= '0;
      reported_r  <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NumChannels; i++) begin
        silent_r[i]     <= '0;
        first_time_r[i] <= '0;
      end
    end else begin
      awaiting_r  <= awaiting_nxt;
      reported_r  <= reported_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < NumChannels; i++) silent_r[i] <= silent_nxt[i];
      if (edge_fire && !awaiting_r[in_data.channel]) begin
        first_time_r[in_data.channel] <= in_data.timestamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centered_mask_r <= 8'd14;
      center_value_r  <= 16'd1500;
      deadband_half_r <= 10'd25;
      reject_low_r    <= 16'd980;
      reject_high_r   <= 16'd2100;
      clamp_low_r     <= 16'd1000;
      clamp_high_r    <= 16'd2000;
      timeout_ticks_r <= 8'd200;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTERED_MASK: centered_mask_r <= cfg_wdata[NumChannels-1:0];
        REG_CENTER_VALUE:  center_value_r  <= cfg_wdata;
        REG_DEADBAND_HALF: deadband_half_r <= cfg_wdata[9:0];
        REG_REJECT_LOW:    reject_low_r    <= cfg_wdata;
        REG_REJECT_HIGH:   reject_high_r   <= cfg_wdata;
        REG_CLAMP_LOW:     clamp_low_r     <= cfg_wdata;
        REG_CLAMP_HIGH:    clamp_high_r    <= cfg_wdata;
        REG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_wdata[7:0];
        default:           timeout_ticks_r <= timeout_ticks_r;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* bench/tb_top.sv */
module tb_top;
  import rcpwm_pkg::*;

  localparam int StuckLimit = 2000;
  localparam int HoldCycles = 150;
  localparam int PrintCap   = 100;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_item_t           in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_data;
  logic               cfg_we = 1'b0;
  cfg_idx_t           cfg_index = REG_CENTERED_MASK;
  logic [CfgBits-1:0] cfg_wdata = '0;

  rc_pwm_pulse_decoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Filter settings as the decoder should hold them
  logic [7:0] cen_mask = 8'd14;
  int cen_value = 1500;
  int dead_half = 25;
  int rej_low = 980;
  int rej_high = 2100;
  int clamp_lo = 1000;
  int clamp_hi = 2000;
  int silence_limit = 200;

  // Per-channel decoder state
  logic        armed [NumChannels] = '{default: 1'b0};
  logic [15:0] t_first [NumChannels] = '{default: 16'd0};
  int          silent [NumChannels] = '{default: 0};
  logic        flagged [NumChannels] = '{default: 1'b0};

  // Generator's view of which channels have an open pulse
  logic        open_edge [NumChannels] = '{default: 1'b0};
  logic [15:0] open_time [NumChannels] = '{default: 16'd0};

  in_item_t  capture_queue[$];
  out_item_t due_reports[$];

  int  mismatches = 0;
  int  reports_seen = 0;
  int  stuck_cycles = 0;
  int  in_gap = 0;
  int  out_gap = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  steady = 1'b0;
  logic in_took = 1'b0;
  logic out_took = 1'b0;

  function automatic int draw_gap();
    if (steady) return 0;
    return $urandom_range(0, 14);
  endfunction

  function automatic logic [15:0] filter_width(int ch, logic [15:0] w);
    int v;
    bit outside;
    v = int'(w);
    outside = (v < rej_low) || (v > rej_high);
    if (cen_mask[ch]) begin
      if ((v >= cen_value - dead_half && v <= cen_value + dead_half) || outside) v = cen_value;
    end else if (outside) begin
      v = clamp_lo;
    end
    if (v < clamp_lo && v > rej_low) v = clamp_lo;
    if (v > clamp_hi && v < rej_high) v = clamp_hi;
    return v[15:0];
  endfunction

  task automatic decode_beat(in_item_t beat);
    int ch;
    logic [15:0] w;
    out_item_t r;
    out_item_t burst[$];
    if (beat.op == OP_EDGE) begin
      ch = int'(beat.channel);
      silent[ch] = 0;
      flagged[ch] = 1'b0;
      if (!armed[ch]) begin
        armed[ch] = 1'b1;
        t_first[ch] = beat.timestamp;
      end else begin
        armed[ch] = 1'b0;
        if (beat.timestamp > t_first[ch]) w = beat.timestamp - t_first[ch];
        else w = 16'hFFFF - t_first[ch] + beat.timestamp;
        r.out_channel = ch[2:0];
        r.raw_width = w;
        r.filtered_width = filter_width(ch, w);
        r.timed_out = 1'b0;
        r.last = 1'b1;
        due_reports.push_back(r);
      end
    end else begin
      for (ch = 0; ch < NumChannels; ch++) begin
        if (silent[ch] < SilentMax) silent[ch]++;
        if (silent[ch] > silence_limit && !flagged[ch] && burst.size() < 8) begin
          flagged[ch] = 1'b1;
          r.out_channel = ch[2:0];
          r.raw_width = FailsafeWidth;
          r.filtered_width = filter_width(ch, FailsafeWidth);
          r.timed_out = 1'b1;
          r.last = 1'b0;
          burst.push_back(r);
        end
      end
      if (burst.size() != 0) burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i]) due_reports.push_back(burst[i]);
    end
  endtask

  task automatic report(string msg);
    mismatches++;
    if (mismatches <= PrintCap) $display("%s", msg);
  endtask

  task automatic check_report(out_item_t got);
    out_item_t want;
    reports_seen++;
    if (due_reports.size() == 0) begin
      report($sformatf("beat %0d: unexpected result on channel %0d", reports_seen,
                       got.out_channel));
    end else begin
      want = due_reports.pop_front();
      if (got.out_channel !== want.out_channel)
        report($sformatf("beat %0d: out_channel %0d, want %0d", reports_seen,
                         got.out_channel, want.out_channel));
      if (got.raw_width !== want.raw_width)
        report($sformatf("beat %0d: raw_width %0d, want %0d", reports_seen,
                         got.raw_width, want.raw_width));
      if (got.filtered_width !== want.filtered_width)
        report($sformatf("beat %0d: filtered_width %0d, want %0d", reports_seen,
                         got.filtered_width, want.filtered_width));
      if (got.timed_out !== want.timed_out)
        report($sformatf("beat %0d: timed_out %0b, want %0b", reports_seen,
                         got.timed_out, want.timed_out));
      if (got.last !== want.last)
        report($sformatf("beat %0d: last %0b, want %0b", reports_seen,
                         got.last, want.last));
    end
  endtask

  // Monitor: predict on input beats, check output beats
  always @(posedge clk) begin
    in_took <= in_valid && in_ready;
    out_took <= out_valid && out_ready;
    if (rst_n && in_valid && in_ready) decode_beat(in_data);
    if (rst_n && out_valid && out_ready) check_report(out_data);
  end

  // Driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (in_took) in_gap = draw_gap();
      if (in_gap != 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (capture_queue.size() != 0) begin
        in_data <= capture_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver; one long hold lets the output back up into the input
  always @(negedge clk) begin
    if (!hold_done && reports_seen >= 60) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
    end
    if (out_took) out_gap = draw_gap();
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (out_gap != 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == StuckLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic queue_edge(int ch, int ts);
    in_item_t item;
    item.op = OP_EDGE;
    item.channel = ch[2:0];
    item.timestamp = ts[15:0];
    capture_queue.push_back(item);
    open_edge[ch] = !open_edge[ch];
    open_time[ch] = ts[15:0];
  endtask

  task automatic queue_tick();
    in_item_t item;
    item.op = OP_TICK;
    item.channel = 3'($urandom_range(0, 7));
    item.timestamp = 16'($urandom_range(0, 65535));
    capture_queue.push_back(item);
  endtask

  // Aim widths at the filter boundaries most of the time
  function automatic int pick_width();
    int k;
    k = $urandom_range(0, 2);
    k = k - 1;
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 65535);
      1: return cen_value - dead_half + k;
      2: return cen_value + dead_half + k;
      3: return rej_low + k;
      4: return rej_high + k;
      5: return clamp_lo + k;
      6: return clamp_hi + k;
      7: return $urandom_range(0, 1) ? 65535 : 1;
      default: return $urandom_range(rej_low, rej_high);
    endcase
  endfunction

  task automatic queue_random(int count);
    int k;
    int ch;
    for (k = 0; k < count; k++) begin
      ch = $urandom_range(0, 7);
      case ($urandom_range(0, 9))
        0, 1: queue_tick();
        2: queue_edge(ch, $urandom_range(0, 65535));
        default: begin
          if (open_edge[ch]) queue_edge(ch, open_time[ch] + pick_width());
          else queue_edge(ch, $urandom_range(0, 65535));
        end
      endcase
    end
  endtask

  // Check at the rising edge, where the driver's queue and in_valid are stable
  task automatic settle();
    do @(posedge clk);
    while (capture_queue.size() != 0 || in_valid || due_reports.size() != 0);
    // allow a tick that times nothing out to finish
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[15:0];
    case (idx)
      REG_CENTERED_MASK: cen_mask = value[7:0];
      REG_CENTER_VALUE:  cen_value = value & 16'hFFFF;
      REG_DEADBAND_HALF: dead_half = value & 10'h3FF;
      REG_REJECT_LOW:    rej_low = value & 16'hFFFF;
      REG_REJECT_HIGH:   rej_high = value & 16'hFFFF;
      REG_CLAMP_LOW:     clamp_lo = value & 16'hFFFF;
      REG_CLAMP_HIGH:    clamp_hi = value & 16'hFFFF;
      REG_TIMEOUT_TICKS: silence_limit = value & 8'hFF;
      default: ;
    endcase
  endtask

  task automatic retune(int mask, int centre, int dead, int rlo, int rhi,
                        int clo, int chi, int tmo);
    settle();
    write_reg(REG_CENTERED_MASK, mask);
    write_reg(REG_CENTER_VALUE, centre);
    write_reg(REG_DEADBAND_HALF, dead);
    write_reg(REG_REJECT_LOW, rlo);
    write_reg(REG_REJECT_HIGH, rhi);
    write_reg(REG_CLAMP_LOW, clo);
    write_reg(REG_CLAMP_HIGH, chi);
    write_reg(REG_TIMEOUT_TICKS, tmo);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int lo;
    int hi;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Power-up settings: timestamp extremes, wrap, deadband and snap edges
    queue_edge(0, 0);
    queue_edge(0, 0);
    queue_edge(1, 65535);
    queue_edge(1, 0);
    queue_edge(2, 1000);
    queue_edge(2, 2500);
    queue_edge(3, 100);
    queue_edge(3, 1090);
    queue_edge(4, 65000);
    queue_edge(4, 1514);
    queue_edge(5, 7);
    queue_edge(5, 1241);
    queue_edge(7, 16'hAAAA);
    queue_edge(7, 16'h5555);
    queue_edge(6, 0);
    queue_edge(6, 65535);
    queue_tick();

    // Everything centred, nothing rejected, fail on the first silent tick
    retune(8'hFF, 1500, 0, 0, 65535, 0, 65535, 0);
    queue_tick();
    queue_tick();
    queue_edge(6, 300);
    queue_tick();
    queue_random(50);

    // Nothing centred, everything rejected, timeout never fires
    retune(8'h00, 65535, 1000, 65535, 0, 65535, 0, 255);
    queue_random(40);

    // Near power-up values with short timeouts; no idling on either side
    retune($urandom_range(0, 255), 1500, $urandom_range(0, 100), 980, 2100, 1000, 2000,
           $urandom_range(1, 4));
    steady = 1'b1;
    queue_random(80);

    lo = $urandom_range(0, 3000);
    hi = lo + $urandom_range(0, 3000);
    retune($urandom_range(0, 255), $urandom_range(lo, hi), $urandom_range(0, 1000), lo, hi,
           lo + $urandom_range(0, 100), hi - $urandom_range(0, 100), $urandom_range(1, 8));
    steady = 1'b0;
    queue_random(80);

    retune($urandom_range(0, 255), $urandom_range(0, 65535), 1000, $urandom_range(0, 65535),
           $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535), 1);
    queue_random(40);

    settle();
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
